/* rtl/txtrep_pkg.sv */
// shared types, constants and helpers for the txt record entry parser
// no dependencies
`default_nettype none
package txtrep_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_MAX     = 16;
	localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W       = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int LEN_W       = $clog2(KEY_MAX + 1);

	localparam logic [7:0] SEPARATOR = 8'h3D;

	localparam logic [1:0] ROLE_LEN = 2'd0;
	localparam logic [1:0] ROLE_KEY = 2'd1;
	localparam logic [1:0] ROLE_SEP = 2'd2;
	localparam logic [1:0] ROLE_VAL = 2'd3;

	localparam logic [1:0] KIND_KEY_ONLY = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_VALUE    = 2'd2;

	localparam logic [2:0] V_ACCEPT = 3'd0;
	localparam logic [2:0] V_EMPTY  = 3'd1;
	localparam logic [2:0] V_DUP    = 3'd2;
	localparam logic [2:0] V_FULL   = 3'd3;
	localparam logic [2:0] V_LONG   = 3'd4;
	localparam logic [2:0] V_PAD    = 3'd5;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_role;
		logic       entry_done;
		logic [1:0] entry_kind;
		logic [2:0] entry_verdict;
		logic [3:0] entry_slot;
		logic       record_done;
		logic       record_status;
	} out_item_t;

	typedef struct packed {
		logic               clear;
		logic               start;
		logic               key_step;
		logic               done;
		logic               accept;
		logic               wr_ok;
		logic [SLOT_W-1:0]  wr_slot;
		logic [COUNT_W-1:0] count;
		logic [7:0]         pos;
		logic [7:0]         key_byte;
		logic [7:0]         key_len;
	} cell_ctl_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/txtrep_if.sv */
// valid/ready channel interfaces for record bytes and parse results
// depends on txtrep_pkg
`default_nettype none
interface txtrep_in_if;
	logic                valid;
	logic                ready;
	txtrep_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface txtrep_out_if;
	logic                 valid;
	logic                 ready;
	txtrep_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/txt_record_entry_parser.sv */
// txt record entry parser top level: deframing, role tagging and verdicts
// depends on txtrep_pkg, txtrep_if and txtrep_cell
// One result item per record byte, one per cycle unless tx stalls: each byte is classified
// in the cycle it is accepted and the result sits in an output register, so a new byte is
// taken whenever that register is empty or being emptied. Duplicate keys are found by a row
// of slot cells, one per table slot, which compare each key byte as it arrives (ASCII case
// folded) and pass their verdict along the row. The table clears itself on the last record
// byte; no setup is needed after reset.
`default_nettype none
module txt_record_entry_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	txtrep_in_if.sink   rx,
	txtrep_out_if.source tx
);
	import txtrep_pkg::*;

	logic               in_entry_q;
	logic [7:0]         bytes_left_q;
	logic [7:0]         key_len_q;
	logic               saw_sep_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic       acc;
	logic [7:0] b;
	logic       is_key;
	logic [7:0] key_len_new;
	logic [7:0] left_new;
	logic       fin;
	logic       dup;
	logic       full;
	out_item_t  res;
	cell_ctl_t  ctl;
	logic [MAX_ENTRIES:0] dup_chain;

	assign rx.ready = !out_valid_q || tx.ready;
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.data.in_byte;
	assign full     = count_q >= COUNT_W'(MAX_ENTRIES);

	assign is_key      = in_entry_q && !saw_sep_q && b != SEPARATOR;
	assign key_len_new = (is_key && key_len_q != 8'hFF) ? key_len_q + 8'd1 : key_len_q;
	assign left_new    = bytes_left_q - 8'd1;
	assign fin         = in_entry_q && left_new == 8'd0;

	always_comb begin
		ctl          = '0;
		ctl.clear    = acc && rx.data.last_byte;
		ctl.start    = acc && !in_entry_q && b != 8'd0;
		ctl.key_step = acc && is_key;
		ctl.done     = acc && fin;
		ctl.wr_ok    = !full;
		ctl.wr_slot  = count_q[SLOT_W-1:0];
		ctl.count    = count_q;
		ctl.pos      = key_len_q;
		ctl.key_byte = b;
		ctl.key_len  = key_len_new;
		ctl.accept   = acc && fin && res.entry_verdict == V_ACCEPT;
	end

	assign dup_chain[0] = 1'b0;
	assign dup = dup_chain[MAX_ENTRIES];

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		txtrep_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_idx (SLOT_W'(i)),
			.ctl      (ctl),
			.dup_in   (dup_chain[i]),
			.dup_out  (dup_chain[i+1])
		);
	end

	always_comb begin
		res          = '0;
		res.out_byte = b;
		res.record_done = rx.data.last_byte;
		if (!in_entry_q) begin
			res.byte_role = ROLE_LEN;
			if (b == 8'd0) begin
				res.entry_done    = 1'b1;
				res.entry_verdict = V_PAD;
			end
		end else begin
			if (saw_sep_q) res.byte_role = ROLE_VAL;
			else if (b == SEPARATOR) res.byte_role = ROLE_SEP;
			else res.byte_role = ROLE_KEY;
			if (fin) begin
				res.entry_done = 1'b1;
				if (!saw_sep_q && b != SEPARATOR) res.entry_kind = KIND_KEY_ONLY;
				else if (!saw_sep_q) res.entry_kind = KIND_EMPTY;
				else res.entry_kind = KIND_VALUE;
				priority if (key_len_new == 8'd0) begin
					res.entry_verdict = V_EMPTY;
				end else if (dup) begin
					res.entry_verdict = V_DUP;
				end else if (key_len_new > 8'(KEY_MAX)) begin
					res.entry_verdict = V_LONG;
				end else if (full) begin
					res.entry_verdict = V_FULL;
				end else begin
					res.entry_verdict = V_ACCEPT;
					res.entry_slot    = 4'(count_q);
				end
			end
		end
		if (rx.data.last_byte) res.record_status = in_entry_q ? !fin : (b != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_entry_q   <= 1'b0;
			bytes_left_q <= '0;
			key_len_q    <= '0;
			saw_sep_q    <= 1'b0;
			count_q      <= '0;
		end else if (acc) begin
			if (rx.data.last_byte) begin
				in_entry_q   <= 1'b0;
				bytes_left_q <= '0;
				key_len_q    <= '0;
				saw_sep_q    <= 1'b0;
				count_q      <= '0;
			end else if (!in_entry_q) begin
				if (b != 8'd0) begin
					in_entry_q   <= 1'b1;
					bytes_left_q <= b;
					key_len_q    <= '0;
					saw_sep_q    <= 1'b0;
				end
			end else begin
				bytes_left_q <= left_new;
				key_len_q    <= key_len_new;
				if (!saw_sep_q && b == SEPARATOR) saw_sep_q <= 1'b1;
				if (fin) in_entry_q <= 1'b0;
				if (ctl.accept) count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx.ready) begin
			out_valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) out_q <= res;
	end

	assign tx.valid = out_valid_q;
	assign tx.data  = out_q;

`ifndef SYNTHESIS
	a_entry_left : assert property (@(posedge clk) disable iff (!arst_n)
		in_entry_q |-> bytes_left_q != 8'd0)
		else $error("open entry with nothing owed");
	a_record_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rx.data.last_byte) |=> (count_q == '0 && !in_entry_q))
		else $error("store not cleared at record end");
	a_slot_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.entry_verdict != V_ACCEPT) |-> out_q.entry_slot == 4'd0)
		else $error("slot given to a rejected entry");
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_ENTRIES))
		else $error("entry count past table size");
`endif

endmodule
`default_nettype wire

/* rtl/txtrep_cell.sv */
// one key table slot: stored key, its length and the running match flag
// depends on txtrep_pkg; duplicate result chains to the neighbouring cell
`default_nettype none
module txtrep_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [txtrep_pkg::SLOT_W-1:0] slot_idx,
	input  wire txtrep_pkg::cell_ctl_t     ctl,
	input  wire logic                      dup_in,
	output logic                           dup_out
);
	import txtrep_pkg::*;

	logic [7:0]       key_q [KEY_MAX];
	logic [LEN_W-1:0] len_q;
	logic             flag_q;
	logic             in_use;
	logic             mismatch;
	logic             flag_upd;
	logic             pos_ok;
	logic [POS_W-1:0] pos_idx;

	assign in_use  = {{(COUNT_W-SLOT_W){1'b0}}, slot_idx} < ctl.count;
	assign pos_ok  = ctl.pos < 8'(KEY_MAX);
	assign pos_idx = ctl.pos[POS_W-1:0];

	always_comb begin
		mismatch = 1'b1;
		if (pos_ok && ctl.pos < 8'(len_q))
			mismatch = fold(key_q[pos_idx]) != fold(ctl.key_byte);
	end

	assign flag_upd = (ctl.key_step && mismatch) ? 1'b0 : flag_q;
	assign dup_out  = dup_in | (ctl.done & flag_upd & (8'(len_q) == ctl.key_len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctl.clear || ctl.done) begin
			flag_q <= 1'b0;
		end else if (ctl.start) begin
			flag_q <= in_use;
		end else begin
			flag_q <= flag_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.key_step && ctl.wr_ok && ctl.wr_slot == slot_idx && pos_ok)
			key_q[pos_idx] <= ctl.key_byte;
		if (ctl.accept && ctl.wr_slot == slot_idx)
			len_q <= ctl.key_len[LEN_W-1:0];
	end

endmodule
`default_nettype wire

/* tb/txt_record_entry_parser_tb.sv */
// testbench for the txt record entry parser: directed and random records with
// a byte-level predictor of entry verdicts and duplicate detection
// depends on txtrep_pkg, txtrep_if and the txt_record_entry_parser rtl
`timescale 1ns / 1ps
module txt_record_entry_parser_tb;
	import txtrep_pkg::*;

	logic clk;
	logic arst_n;
	txtrep_in_if  rx();
	txtrep_out_if tx();

	txt_record_entry_parser dut (.clk(clk), .arst_n(arst_n), .rx(rx), .tx(tx));

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// parser state mirror
	logic        p_in_entry;
	logic [7:0]  p_left;
	int          p_keylen;
	logic        p_sep;
	logic [MAX_ENTRIES-1:0] p_match;
	logic [7:0]  p_keys [MAX_ENTRIES][KEY_MAX];
	int          p_lens [MAX_ENTRIES];
	int          p_count;

	out_item_t expected_results[$];
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  failed;
	int  quiet_cycles;

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic void clear_parser();
		p_in_entry = 0;
		p_left = 0;
		p_keylen = 0;
		p_sep = 0;
		p_match = '0;
		p_count = 0;
	endfunction

	function automatic out_item_t parse_byte(input logic [7:0] b, input logic last);
		out_item_t r;
		logic dup;
		r = '0;
		r.out_byte = b;
		r.record_done = last;
		if (!p_in_entry) begin
			r.byte_role = ROLE_LEN;
			if (b == 0) begin
				r.entry_done = 1;
				r.entry_verdict = V_PAD;
			end else begin
				p_in_entry = 1;
				p_left = b;
				p_keylen = 0;
				p_sep = 0;
				p_match = '0;
				for (int s = 0; s < p_count; s++) p_match[s] = 1;
			end
		end else begin
			if (p_sep) r.byte_role = ROLE_VAL;
			else if (b == SEPARATOR) begin
				r.byte_role = ROLE_SEP;
				p_sep = 1;
			end else begin
				r.byte_role = ROLE_KEY;
				for (int s = 0; s < p_count; s++)
					if (p_match[s] && (p_keylen >= p_lens[s] || p_keylen >= KEY_MAX ||
						lower(p_keys[s][p_keylen]) != lower(b)))
						p_match[s] = 0;
				if (p_count < MAX_ENTRIES && p_keylen < KEY_MAX)
					p_keys[p_count][p_keylen] = b;
				if (p_keylen < 255) p_keylen++;
			end
			p_left = p_left - 8'd1;
			if (p_left == 0) begin
				r.entry_done = 1;
				p_in_entry = 0;
				r.entry_kind = !p_sep ? KIND_KEY_ONLY :
					(r.byte_role == ROLE_SEP) ? KIND_EMPTY : KIND_VALUE;
				dup = 0;
				for (int s = 0; s < p_count; s++)
					if (p_match[s] && p_lens[s] == p_keylen) dup = 1;
				if (p_keylen == 0) r.entry_verdict = V_EMPTY;
				else if (dup) r.entry_verdict = V_DUP;
				else if (p_keylen > KEY_MAX) r.entry_verdict = V_LONG;
				else if (p_count >= MAX_ENTRIES) r.entry_verdict = V_FULL;
				else begin
					r.entry_verdict = V_ACCEPT;
					r.entry_slot = p_count[3:0];
					p_lens[p_count] = p_keylen;
					p_count++;
				end
				p_match = '0;
			end
		end
		if (last) begin
			r.record_status = p_in_entry;
			clear_parser();
		end
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.data <= '{in_byte: b, last_byte: last};
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		expected_results.push_back(parse_byte(b, last));
	endtask

	task automatic send_entry(input logic [7:0] bytes[$]);
		send_byte(8'(bytes.size()), 0);
		foreach (bytes[i]) send_byte(bytes[i], 0);
	endtask

	always @(posedge clk) begin
		tx.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && tx.valid && tx.ready) begin
			out_item_t e, a;
			a = tx.data;
			if (expected_results.size() == 0) begin
				$error("unexpected item %h", a);
				failed = 1;
			end else begin
				e = expected_results.pop_front();
				if (a.out_byte !== e.out_byte) begin
					$error("out_byte exp %h got %h", e.out_byte, a.out_byte); failed = 1;
				end
				if (a.byte_role !== e.byte_role) begin
					$error("byte_role exp %0d got %0d", e.byte_role, a.byte_role); failed = 1;
				end
				if (a.entry_done !== e.entry_done) begin
					$error("entry_done exp %0d got %0d", e.entry_done, a.entry_done); failed = 1;
				end
				if (a.entry_kind !== e.entry_kind) begin
					$error("entry_kind exp %0d got %0d", e.entry_kind, a.entry_kind); failed = 1;
				end
				if (a.entry_verdict !== e.entry_verdict) begin
					$error("entry_verdict exp %0d got %0d", e.entry_verdict, a.entry_verdict);
					failed = 1;
				end
				if (a.entry_slot !== e.entry_slot) begin
					$error("entry_slot exp %0d got %0d", e.entry_slot, a.entry_slot); failed = 1;
				end
				if (a.record_done !== e.record_done) begin
					$error("record_done exp %0d got %0d", e.record_done, a.record_done); failed = 1;
				end
				if (a.record_status !== e.record_status) begin
					$error("record_status exp %0d got %0d", e.record_status, a.record_status);
					failed = 1;
				end
			end
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (tx.valid && tx.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] key_char();
		// small alphabet with both cases so duplicates turn up often
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(2));
		if ($urandom_range(1)) c = c - 8'h20;
		return c;
	endfunction

	task automatic test_directed();
		logic [7:0] e[$];
		send_byte(8'h00, 0);                   // padding
		e = '{8'h41, 8'h62};     send_entry(e); // key only, accepted
		e = '{8'h61, 8'h42};     send_entry(e); // duplicate by case
		e = '{8'h3D, 8'h78};     send_entry(e); // empty key
		e = '{8'h63, 8'h3D};     send_entry(e); // empty value
		e = '{8'h64, 8'h3D, 8'h3D, 8'hFF}; send_entry(e); // repeated separator
		e = '{};
		for (int i = 0; i < KEY_MAX + 1; i++) e.push_back(8'h7A);
		send_entry(e);                          // key too long
		send_byte(8'hFF, 1);                    // truncated at length byte
		send_byte(8'h03, 0);
		send_byte(8'h80, 1);                    // truncated in payload
		send_byte(8'h00, 1);                    // padding as last byte
	endtask

	task automatic test_table_full();
		logic [7:0] e[$];
		for (int i = 0; i < MAX_ENTRIES + 2; i++) begin
			e = '{8'h6B, 8'h30 + i[7:0]};
			send_entry(e);
		end
		send_byte(8'h00, 1);
	endtask

	task automatic test_random_records(input int n_items);
		int sent;
		logic [7:0] e[$];
		int len;
		sent = 0;
		while (sent < n_items) begin
			int n_entries;
			n_entries = $urandom_range(20);
			for (int k = 0; k < n_entries; k++) begin
				e = '{};
				case ($urandom_range(9))
					0: begin
						len = $urandom_range(6);
						for (int i = 0; i < len; i++) e.push_back(8'($urandom_range(255)));
					end
					1: begin
						len = $urandom_range(KEY_MAX + 4, KEY_MAX - 1);
						for (int i = 0; i < len; i++) e.push_back(key_char());
					end
					default: begin
						len = $urandom_range(3);
						if ($urandom_range(7) == 0) len = 0;
						for (int i = 0; i < len; i++) e.push_back(key_char());
						if ($urandom_range(2) != 0) begin
							e.push_back(SEPARATOR);
							len = $urandom_range(3);
							for (int i = 0; i < len; i++)
								e.push_back(8'($urandom_range(255)));
						end
					end
				endcase
				if (e.size() == 0 || $urandom_range(15) == 0) begin
					send_byte(8'h00, 0);
					sent++;
				end else begin
					send_entry(e);
					sent += e.size() + 1;
				end
			end
			// close the record: clean, or cut short
			if ($urandom_range(3) == 0) begin
				send_byte(8'($urandom_range(255, 1)), 0);
				send_byte(8'($urandom_range(255)), 1);
				sent += 2;
			end else begin
				send_byte($urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255, 1)), 1);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.data = '0;
		tx.ready = 1'b0;
		failed = 0;
		quiet_cycles = 0;
		clear_parser();
		send_idle_pct = 33;
		recv_stall_pct = 56;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random_records(500);
		send_idle_pct = 56;
		recv_stall_pct = 33;
		test_random_records(500);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_records(500);
		rx.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

/* txt_record_entry_parser.f */
rtl/txtrep_pkg.sv
rtl/txtrep_if.sv
rtl/txtrep_cell.sv
rtl/txt_record_entry_parser.sv
tb/txt_record_entry_parser_tb.sv
